>>> src/rntl_pkg.sv
// Shared types and constants for the recent node table.
`timescale 1ns / 1ps
package rntl_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned CNT_W   = 5;

  typedef enum logic {
    CMD_OBSERVE = 1'b0,
    CMD_QUERY   = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ACT_IGNORED = 3'd0,
    ACT_REFRESH = 3'd1,
    ACT_INSERT  = 3'd2,
    ACT_EVICT   = 3'd3,
    ACT_QUERY   = 3'd4
  } action_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [ID_W-1:0]   node_id;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] window_ms;
  } req_t;

  typedef struct packed {
    action_e           action;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  unique_count;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]   node;
    logic [TIME_W-1:0] seen;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

endpackage

>>> src/recent_node_table_lru_unit.sv
// Top level of the recent node table with least-recently-seen replacement.
`timescale 1ns / 1ps
// Usage:
//   A request (req_i) is taken at the rising edge where start is high and
//   busy is low. cmd OBSERVE records node_id at now_ms; cmd QUERY counts
//   occupied entries whose wrapping age now_ms - seen is at most window_ms.
//   Every request gives exactly one result on rsp_o, marked by
//   result_valid_o for one cycle. The receiver cannot stall; it must take
//   the result in that cycle.
// Timing:
//   The entries sit in one memory with a registered read. A scan issues one
//   read per cycle and checks each entry in the cycle after its read. An
//   observe stops at the first matching or empty entry and its result
//   strobes once that entry is checked; a full scan (eviction or query)
//   strobes once the last entry is checked. An observe of node 0
//   strobes in the next cycle. busy stays high until the result strobes,
//   so one request is in flight at a time and the next may be issued in
//   the strobe cycle. The write-back of an observe happens at the edge
//   that ends the scan, before any read of the next request.
// Reset:
//   rst_ni clears the entry valid flops at once, so the whole table reads
//   as empty; no clearing pass is needed.
module recent_node_table_lru_unit import rntl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic result_valid_o,
  output rsp_t rsp_o
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e               state_q;
  req_t                 req_q;
  logic [IDX_W:0]       rd_idx_q;     // next address to read, may reach ENTRIES
  logic                 chk_vld_q;    // read data due this cycle
  logic [IDX_W-1:0]     chk_idx_q;    // index of that data
  logic [IDX_W-1:0]     victim_q;
  logic [TIME_W-1:0]    victim_age_q;
  logic [CNT_W-1:0]     count_q;
  logic                 res_vld_q;
  rsp_t                 rsp_q;

  tbl_rd_t              rd;
  tbl_wr_t              wr;
  entry_t               ent;
  logic [TIME_W-1:0]    age;
  logic                 last;
  logic                 take_victim;
  logic                 accept;

  rntl_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (rd),
    .rd_data_o (ent),
    .wr_i      (wr)
  );

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  assign age         = req_q.now_ms - ent.seen;
  assign last        = (chk_idx_q == IDX_W'(ENTRIES - 1));
  assign take_victim = (age >= victim_age_q);

  // read issue: one entry per cycle until the end of the table
  always_comb begin
    rd.en   = (state_q == S_SCAN) && (rd_idx_q < (IDX_W + 1)'(ENTRIES));
    rd.addr = rd_idx_q[IDX_W-1:0];
  end

  // write-back decision for an observe, taken on the checked entry
  always_comb begin
    wr.en        = 1'b0;
    wr.addr      = chk_idx_q;
    wr.data.node = req_q.node_id;
    wr.data.seen = req_q.now_ms;
    if (state_q == S_SCAN && chk_vld_q && req_q.cmd == CMD_OBSERVE) begin
      if (ent.node == req_q.node_id || ent.node == '0) begin
        wr.en = 1'b1;
      end else if (last) begin
        wr.en   = 1'b1;
        wr.addr = take_victim ? chk_idx_q : victim_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      chk_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= 1'b0;
      chk_vld_q <= rd.en;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (req_i.cmd == CMD_OBSERVE && req_i.node_id == '0) begin
              // node 0: nothing to record
              res_vld_q <= 1'b1;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (chk_vld_q) begin
            if (req_q.cmd == CMD_QUERY) begin
              if (last) begin
                res_vld_q <= 1'b1;
                state_q   <= S_IDLE;
              end
            end else if (wr.en) begin
              res_vld_q <= 1'b1;
              state_q   <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (rd.en) begin
      chk_idx_q <= rd.addr;
      rd_idx_q  <= rd_idx_q + 1'b1;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_q        <= req_i;
          rd_idx_q     <= '0;
          victim_q     <= '0;
          victim_age_q <= '0;
          count_q      <= '0;
          rsp_q.action       <= ACT_IGNORED;
          rsp_q.slot         <= '0;
          rsp_q.unique_count <= '0;
        end
      end
      S_SCAN: begin
        if (chk_vld_q) begin
          if (req_q.cmd == CMD_QUERY) begin
            if (ent.node != '0 && age <= req_q.window_ms &&
                count_q != {CNT_W{1'b1}}) begin
              count_q            <= count_q + 1'b1;
              rsp_q.unique_count <= count_q + 1'b1;
            end else begin
              rsp_q.unique_count <= count_q;
            end
            rsp_q.action <= ACT_QUERY;
            rsp_q.slot   <= '0;
          end else begin
            if (take_victim) begin
              victim_q     <= chk_idx_q;
              victim_age_q <= age;
            end
            rsp_q.slot         <= SLOT_W'(wr.addr);
            rsp_q.unique_count <= '0;
            if (ent.node == req_q.node_id) begin
              rsp_q.action <= ACT_REFRESH;
            end else if (ent.node == '0) begin
              rsp_q.action <= ACT_INSERT;
            end else begin
              rsp_q.action <= ACT_EVICT;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign result_valid_o = res_vld_q;
  assign rsp_o          = rsp_q;

endmodule

>>> src/rntl_table.sv
// Entry memory: one read port with registered data, one write port, valid flops.
`timescale 1ns / 1ps
module rntl_table import rntl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  tbl_rd_t rd_i,
  output entry_t  rd_data_o,
  input  tbl_wr_t wr_i
);

  entry_t             mem_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  entry_t             rdata_q;
  logic               rvalid_q;

  // payload array, no reset
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  // never-written entries read as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rvalid_q <= valid_q[rd_i.addr];
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the recent node table: random and directed requests, scored per result.
`timescale 1ns / 1ps
module tb_top;
  import rntl_pkg::*;

  // One queued request for the driver. A drain entry carries no request:
  // the driver holds start low at it until every expected result is back.
  typedef struct {
    req_t req;
    bit   drain;
  } stim_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic result_valid_o;
  rsp_t rsp_o;

  stim_t stim_q[$];          // requests waiting to be driven
  rsp_t  pending_rsp_q[$];   // predicted results, oldest first
  logic  req_taken = 1'b0;   // request on req_i was taken at the last rising edge
  int    err_cnt   = 0;
  int    sent_cnt  = 0;
  int    idle_left = 0;
  int    act_tally [8];
  int    max_count = 0;

  // Shadow copy of the node table, updated as each request is taken.
  logic [ID_W-1:0]   shadow_node [ENTRIES];
  logic [TIME_W-1:0] shadow_seen [ENTRIES];

  recent_node_table_lru_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

  always #1 clk_i = ~clk_i;

  // Applies one request to the shadow table and returns the result it must give.
  function automatic rsp_t next_table_rsp(req_t r);
    rsp_t              o;
    int unsigned       cnt;
    int unsigned       victim;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] victim_age;
    o = '0;
    o.action = ACT_IGNORED;
    // Query: occupied entries only, wrapping age against the window.
    if (r.cmd == CMD_QUERY) begin
      cnt = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        age = r.now_ms - shadow_seen[i];
        if (shadow_node[i] != '0 && age <= r.window_ms) cnt++;
      end
      if (cnt > 31) cnt = 31;
      o.action = ACT_QUERY;
      o.unique_count = CNT_W'(cnt);
      return o;
    end
    // Node zero means no sender; nothing changes.
    if (r.node_id == '0) return o;
    // Scan in index order: a hit or the first empty slot ends it.
    victim = 0;
    victim_age = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_node[i] == r.node_id) begin
        shadow_seen[i] = r.now_ms;
        o.action = ACT_REFRESH;
        o.slot = SLOT_W'(i);
        return o;
      end
      if (shadow_node[i] == '0) begin
        shadow_node[i] = r.node_id;
        shadow_seen[i] = r.now_ms;
        o.action = ACT_INSERT;
        o.slot = SLOT_W'(i);
        return o;
      end
      // Oldest wins; >= hands ties to the later index.
      age = r.now_ms - shadow_seen[i];
      if (age >= victim_age) begin
        victim_age = age;
        victim = i;
      end
    end
    shadow_node[victim] = r.node_id;
    shadow_seen[victim] = r.now_ms;
    o.action = ACT_EVICT;
    o.slot = SLOT_W'(victim);
    return o;
  endfunction

  function automatic stim_t observe_req(logic [ID_W-1:0] node, logic [TIME_W-1:0] now);
    stim_t s;
    s.drain = 1'b0;
    s.req.cmd = CMD_OBSERVE;
    s.req.node_id = node;
    s.req.now_ms = now;
    s.req.window_ms = $urandom;   // don't-care on observe, toggled anyway
    return s;
  endfunction

  function automatic stim_t count_req(logic [TIME_W-1:0] now, logic [TIME_W-1:0] window);
    stim_t s;
    s.drain = 1'b0;
    s.req.cmd = CMD_QUERY;
    s.req.node_id = $urandom;     // don't-care on query
    s.req.now_ms = now;
    s.req.window_ms = window;
    return s;
  endfunction

  function automatic logic [ID_W-1:0] fresh_id();
    logic [ID_W-1:0] v;
    do v = $urandom; while (v == '0);
    return v;
  endfunction

  // Driver: new values at the falling edge. A request stays on req_i with
  // start high until it is taken; only then may the next one go out.
  always @(negedge clk_i) begin
    if (rst_ni && (!start || req_taken)) begin
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (stim_q.size() == 0) begin
        start <= 1'b0;
      end else if (stim_q[0].drain) begin
        start <= 1'b0;
        if (pending_rsp_q.size() == 0 && !busy) void'(stim_q.pop_front());
      end else if (!(sent_cnt >= 400 && sent_cnt < 620) && $urandom_range(0, 159) == 0) begin
        // Gap of random length so it lands on any phase of the scan.
        idle_left = $urandom_range(1, 24);
        start <= 1'b0;
      end else begin
        req_i <= stim_q.pop_front().req;
        start <= 1'b1;
        sent_cnt++;
      end
    end
  end

  // Monitor: sample at the rising edge. The result of the previous request
  // is scored before a request taken at the same edge is predicted.
  always @(posedge clk_i) begin : scoreboard
    rsp_t want;
    req_taken <= rst_ni && start && !busy;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (pending_rsp_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual action %0d slot %0d count %0d",
                   $time, rsp_o.action, rsp_o.slot, rsp_o.unique_count);
          err_cnt++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (rsp_o.action !== want.action) begin
            $display("%0t: action mismatch: expected %0d actual %0d",
                     $time, want.action, rsp_o.action);
            err_cnt++;
          end
          if (rsp_o.slot !== want.slot) begin
            $display("%0t: slot mismatch: expected %0d actual %0d",
                     $time, want.slot, rsp_o.slot);
            err_cnt++;
          end
          if (rsp_o.unique_count !== want.unique_count) begin
            $display("%0t: unique_count mismatch: expected %0d actual %0d",
                     $time, want.unique_count, rsp_o.unique_count);
            err_cnt++;
          end
        end
      end
      if (start && !busy) begin
        want = next_table_rsp(req_i);
        act_tally[want.action]++;
        if (int'(want.unique_count) > max_count) max_count = want.unique_count;
        pending_rsp_q.push_back(want);
      end
    end
  end

  initial begin : main
    logic [ID_W-1:0]   pool [48];
    logic [TIME_W-1:0] clk_ms;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] window;
    int                pool_n;
    int                r;
    stim_t             hold;

    for (int i = 0; i < ENTRIES; i++) begin
      shadow_node[i] = '0;
      shadow_seen[i] = '0;
    end
    for (int i = 0; i < 8; i++) act_tally[i] = 0;

    // Directed: empty table, node zero, wrapping ages, fill, ties, oldest.
    stim_q.push_back(count_req('0, '1));               // empty entries never count
    stim_q.push_back(observe_req('0, 32'd5));          // node zero ignored
    stim_q.push_back(observe_req('1, '1));             // max id at max time
    stim_q.push_back(count_req('0, '0));               // age 1 across the wrap
    stim_q.push_back(count_req(32'hFFFF_FFFE, 32'hFFFF_FFFE)); // seen in the future
    stim_q.push_back(count_req('0, 32'd1));
    for (int i = 1; i < ENTRIES; i++)
      stim_q.push_back(observe_req(32'h8000_0000 | i, 32'd7));
    stim_q.push_back(observe_req('1, 32'd7));          // refresh, all ages now equal
    stim_q.push_back(observe_req(32'h0000_1234, 32'd7)); // tie: last index evicted
    stim_q.push_back(observe_req(32'h8000_0003, 32'd50));
    stim_q.push_back(observe_req(32'h0000_0042, 32'd60)); // oldest evicted
    stim_q.push_back(count_req(32'd60, 32'd10));
    stim_q.push_back(count_req(32'd60, '1));           // full table

    // Random: three phases with growing id pools (few, mixed, mostly
    // evictions), the first two each closed by a full drain of the pipeline.
    clk_ms = $urandom;
    for (int p = 0; p < 3; p++) begin
      pool_n = (p == 0) ? 6 : (p == 1) ? 20 : 48;
      for (int i = 0; i < 48; i++) pool[i] = fresh_id();
      for (int n = 0; n < 342; n++) begin
        if ($urandom_range(0, 32) == 0) clk_ms = $urandom;
        else clk_ms += $urandom_range(0, 300);
        now = clk_ms;
        if ($urandom_range(0, 29) == 0) now = clk_ms - $urandom_range(1, 600);
        case ($urandom_range(0, 5))
          0:       window = '0;
          1:       window = '1;
          2, 3:    window = $urandom_range(0, 1500);
          default: window = $urandom;
        endcase
        r = $urandom_range(0, 99);
        if (r < 4)       stim_q.push_back(observe_req('0, now));
        else if (r < 66) stim_q.push_back(observe_req(pool[$urandom_range(0, pool_n - 1)], now));
        else if (r < 72) stim_q.push_back(observe_req(fresh_id(), now));
        else             stim_q.push_back(count_req(now, window));
        if ($urandom_range(0, 19) == 0) pool[$urandom_range(0, pool_n - 1)] = fresh_id();
      end
      if (p < 2) begin
        hold.drain = 1'b1;
        hold.req = '0;
        stim_q.push_back(hold);
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last request to go out and its result to come back,
    // then watch on for stray strobes.
    do @(negedge clk_i);
    while (stim_q.size() != 0 || start || pending_rsp_q.size() != 0);
    repeat (ENTRIES + 8) @(posedge clk_i);

    $display("Ran %0d requests: %0d refresh, %0d insert, %0d evict, %0d ignored, %0d query.",
             sent_cnt, act_tally[ACT_REFRESH], act_tally[ACT_INSERT], act_tally[ACT_EVICT],
             act_tally[ACT_IGNORED], act_tally[ACT_QUERY]);
    $display("Largest node count returned by a query: %0d; mismatches: %0d.",
             max_count, err_cnt);
    if (err_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
src/rntl_pkg.sv
src/rntl_table.sv
src/recent_node_table_lru_unit.sv
tb/tb_top.sv
